/* design/rqi_pkg.sv */
// Shared widths, constants and types of the ray / quadric intersection pipeline.
package rqi_pkg;

   // Fixed-point format of coordinates and coefficients.
   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;

   // Product counts: quadratic coordinate products and linear coefficient products.
   localparam int NQ = 21;
   localparam int NL = 6;

   // Accumulator widths of the quadratic build.
   localparam int HI_W  = 68;
   localparam int LO_W  = 70;
   localparam int LIN_W = 66;
   localparam int SUM_W = 104;

   // a, b, c in Q.F, kept inside [-2^59, 2^59).
   localparam int Q_W  = 60;
   localparam int HALF = Q_W / 2;

   // Discriminant, square root and divider widths.
   localparam int DISC_W     = 123;
   localparam int RAD_W      = 122;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SREM_W     = 64;
   localparam int NUM_W      = ROOT_W + 2;
   localparam int MAG_W      = NUM_W - 1;
   localparam int DEN_W      = Q_W + 1;
   localparam int QUO_W      = 32;
   localparam int N_W        = MAG_W + FRAC_BITS;
   localparam int SQRT_CELLS = ROOT_W;
   localparam int DIV_CELLS  = QUO_W;

   // Thresholds on t (Q.F) and on the discriminant (Q.2F).
   localparam longint EPS_T    = longint'((((64'd1 << FRAC_BITS) * 5) + 5000) / 10000);
   localparam longint EPS_D_HI = longint'((((64'd1 << (2 * FRAC_BITS)) * 5) + 5000) / 10000);
   localparam longint EPS_D_LO = longint'(((64'd1 << (2 * FRAC_BITS)) + 5000) / 10000);

   // How many roots the discriminant allows.
   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_TWO     = 2'd1,
      MODE_TANGENT = 2'd2
   } mode_type;

   // Which root is reported.
   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_FAR     = 2'd1,
      KIND_NEAR    = 2'd2,
      KIND_TANGENT = 2'd3
   } kind_type;

   // Raw ray fields as they arrive on the input word.
   typedef struct packed {
      logic [31:0] origin_z;
      logic [31:0] origin_y;
      logic [31:0] origin_x;
      logic [31:0] dir_z;
      logic [31:0] dir_y;
      logic [31:0] dir_x;
   } ray_type;

   // The ten surface coefficients, signed Q16.16.
   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
      logic signed [31:0] e;
      logic signed [31:0] f;
      logic signed [31:0] g;
      logic signed [31:0] h;
      logic signed [31:0] j;
      logic signed [31:0] k;
   } coef_type;

   // Result of the quadratic build and discriminant test.
   typedef struct packed {
      logic signed [Q_W-1:0] a;
      logic signed [Q_W-1:0] b;
      mode_type              mode;
      logic [RAD_W-1:0]      rad;
   } quad_type;

   // Word handed along the square-root cells.
   typedef struct packed {
      logic [RAD_W-1:0]      rad;
      logic [ROOT_W-1:0]     root;
      logic [SREM_W-1:0]     rem;
      logic signed [Q_W-1:0] a;
      logic signed [Q_W-1:0] b;
      mode_type              mode;
   } sq_type;

   // Word handed along the divider cells; two quotients are formed side by side.
   typedef struct packed {
      logic [DEN_W-1:0] rem1;
      logic [DEN_W-1:0] rem2;
      logic [QUO_W-1:0] n1;
      logic [QUO_W-1:0] n2;
      logic [QUO_W-1:0] q1;
      logic [QUO_W-1:0] q2;
      logic [DEN_W-1:0] dm;
      logic             ovf1;
      logic             ovf2;
      logic             neg1;
      logic             neg2;
      logic             a_pos;
      mode_type         mode;
   } dv_type;

endpackage

/* design/rqi_sqrt_cell.sv */
// One cell of the square-root chain: settles one root bit per cycle while enabled.
module rqi_sqrt_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            up_vld,
   input  rqi_pkg::sq_type up_data,
   output logic            dn_vld,
   output rqi_pkg::sq_type dn_data
);
   import rqi_pkg::*;

   logic [SREM_W+1:0] cur;
   logic [SREM_W+1:0] trial;
   logic              fits;
   sq_type            data_in;
   sq_type            data_ff;
   logic              vld_ff;

   // Bring down two radicand bits and try the next root bit.
   always_comb begin
      cur   = {up_data.rem, up_data.rad[RAD_W-1 -: 2]};
      trial = (SREM_W+2)'({up_data.root, 2'b01});
      fits  = cur >= trial;
      data_in     = up_data;
      data_in.rad = up_data.rad << 2;
      if (fits) begin
         data_in.rem  = SREM_W'(cur - trial);
         data_in.root = {up_data.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_in.rem  = SREM_W'(cur);
         data_in.root = {up_data.root[ROOT_W-2:0], 1'b0};
      end
   end

   // Cell register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_data = data_ff;

endmodule

/* design/rqi_div_cell.sv */
// One cell of the divider chain: settles one bit of both quotients per cycle while enabled.
module rqi_div_cell (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            up_vld,
   input  rqi_pkg::dv_type up_data,
   output logic            dn_vld,
   output rqi_pkg::dv_type dn_data
);
   import rqi_pkg::*;

   logic [DEN_W:0] cur1;
   logic [DEN_W:0] cur2;
   logic           fit1;
   logic           fit2;
   dv_type         data_in;
   dv_type         data_ff;
   logic           vld_ff;

   // Restoring step on both lanes against the shared divisor.
   always_comb begin
      cur1 = {up_data.rem1, up_data.n1[QUO_W-1]};
      cur2 = {up_data.rem2, up_data.n2[QUO_W-1]};
      fit1 = cur1 >= {1'b0, up_data.dm};
      fit2 = cur2 >= {1'b0, up_data.dm};
      data_in      = up_data;
      data_in.n1   = up_data.n1 << 1;
      data_in.n2   = up_data.n2 << 1;
      data_in.q1   = {up_data.q1[QUO_W-2:0], fit1};
      data_in.q2   = {up_data.q2[QUO_W-2:0], fit2};
      data_in.rem1 = fit1 ? DEN_W'(cur1 - {1'b0, up_data.dm}) : DEN_W'(cur1);
      data_in.rem2 = fit2 ? DEN_W'(cur2 - {1'b0, up_data.dm}) : DEN_W'(cur2);
   end

   // Cell register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= up_vld;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign dn_vld  = vld_ff;
   assign dn_data = data_ff;

endmodule

/* design/rqi_quad.sv */
// Quadratic build: forms a, b, c from the ray and coefficients, then the discriminant.
module rqi_quad (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              up_vld,
   input  rqi_pkg::ray_type  ray,
   input  rqi_pkg::coef_type coef,
   output logic              dn_vld,
   output rqi_pkg::quad_type dn_data
);
   import rqi_pkg::*;

   logic signed [31:0] dx, dy, dz, ex, ey, ez;
   logic signed [31:0] cf [NQ];

   logic signed [63:0] qp_in [NQ];
   logic signed [63:0] qp_ff [NQ];
   logic signed [63:0] lp_in [NL];
   logic signed [63:0] lp_ff [NL];

   logic signed [63:0] ph_in [NQ];
   logic signed [63:0] ph_ff [NQ];
   logic signed [64:0] pl_in [NQ];
   logic signed [64:0] pl_ff [NQ];
   logic signed [63:0] lp2_ff [NL];

   logic signed [HI_W-1:0]  ahi_in, bhi_in, chi_in, ahi_ff, bhi_ff, chi_ff;
   logic signed [LO_W-1:0]  alo_in, blo_in, clo_in, alo_ff, blo_ff, clo_ff;
   logic signed [LIN_W-1:0] bl_in, cl_in, bl_ff, cl_ff;

   logic signed [SUM_W-1:0] sa_in, sb_in, sc_in, sa_ff, sb_ff, sc_ff;
   logic signed [SUM_W-1:0] fa, fb, fc;

   logic signed [Q_W-1:0] qa_ff, qb_ff, qc_ff;
   logic                  ok5_in, ok5_ff;

   logic signed [HALF-1:0]   ah, bh, ch;
   logic signed [HALF:0]     al, bl, cl;
   logic signed [2*HALF-1:0] bhh_in, ahh_in, bhh_ff, ahh_ff;
   logic signed [2*HALF:0]   bhl_in, ahl_in, alh_in, bhl_ff, ahl_ff, alh_ff;
   logic signed [2*HALF+1:0] bll_in, all_in, bll_ff, all_ff;
   logic signed [Q_W-1:0]    a6_ff, b6_ff;
   logic                     ok6_ff;

   logic signed [DISC_W-1:0] bb_in, ac_in, bb_ff, ac_ff;
   logic signed [Q_W-1:0]    a7_ff, b7_ff;
   logic                     ok7_ff;

   logic signed [DISC_W-1:0] disc_in, disc_ff;
   logic signed [Q_W-1:0]    a8_ff, b8_ff;
   logic                     ok8_ff;

   quad_type out_in, out_ff;
   logic     two, tan;
   logic [8:0] vld_ff;

   // Sign-extended coordinates and the coefficient of each quadratic product.
   always_comb begin
      dx = 32'($signed(ray.dir_x[COORD_WIDTH-1:0]));
      dy = 32'($signed(ray.dir_y[COORD_WIDTH-1:0]));
      dz = 32'($signed(ray.dir_z[COORD_WIDTH-1:0]));
      ex = 32'($signed(ray.origin_x[COORD_WIDTH-1:0]));
      ey = 32'($signed(ray.origin_y[COORD_WIDTH-1:0]));
      ez = 32'($signed(ray.origin_z[COORD_WIDTH-1:0]));
      cf[0]  = coef.a; cf[1]  = coef.b; cf[2]  = coef.c;
      cf[3]  = coef.d; cf[4]  = coef.e; cf[5]  = coef.f;
      cf[6]  = coef.a; cf[7]  = coef.b; cf[8]  = coef.c;
      cf[9]  = coef.d; cf[10] = coef.d; cf[11] = coef.e;
      cf[12] = coef.e; cf[13] = coef.f; cf[14] = coef.f;
      cf[15] = coef.a; cf[16] = coef.b; cf[17] = coef.c;
      cf[18] = coef.d; cf[19] = coef.e; cf[20] = coef.f;
   end

   // Stage 1: coordinate products and linear coefficient products.
   always_comb begin
      qp_in[0]  = dx * dx; qp_in[1]  = dy * dy; qp_in[2]  = dz * dz;
      qp_in[3]  = dx * dy; qp_in[4]  = dy * dz; qp_in[5]  = dx * dz;
      qp_in[6]  = ex * dx; qp_in[7]  = ey * dy; qp_in[8]  = ez * dz;
      qp_in[9]  = ex * dy; qp_in[10] = ey * dx; qp_in[11] = ey * dz;
      qp_in[12] = ez * dy; qp_in[13] = ez * dx; qp_in[14] = ex * dz;
      qp_in[15] = ex * ex; qp_in[16] = ey * ey; qp_in[17] = ez * ez;
      qp_in[18] = ex * ey; qp_in[19] = ey * ez; qp_in[20] = ez * ex;
      lp_in[0] = coef.g * dx; lp_in[1] = coef.h * dy; lp_in[2] = coef.j * dz;
      lp_in[3] = coef.g * ex; lp_in[4] = coef.h * ey; lp_in[5] = coef.j * ez;
   end

   // Stage 2: coefficient times each half of a coordinate product.
   always_comb begin
      for (int i = 0; i < NQ; i++) begin
         ph_in[i] = cf[i] * $signed(qp_ff[i][63:32]);
         pl_in[i] = cf[i] * $signed({1'b0, qp_ff[i][31:0]});
      end
   end

   // Stage 3: sum the high and low halves per coefficient of the quadratic.
   always_comb begin
      ahi_in = '0; alo_in = '0;
      bhi_in = '0; blo_in = '0;
      chi_in = '0; clo_in = '0;
      for (int i = 0; i < 6; i++) begin
         if (i >= 3) begin
            ahi_in = ahi_in + (HI_W'(ph_ff[i]) <<< 1);
            alo_in = alo_in + (LO_W'(pl_ff[i]) <<< 1);
            chi_in = chi_in + (HI_W'(ph_ff[i+15]) <<< 1);
            clo_in = clo_in + (LO_W'(pl_ff[i+15]) <<< 1);
         end else begin
            ahi_in = ahi_in + HI_W'(ph_ff[i]);
            alo_in = alo_in + LO_W'(pl_ff[i]);
            chi_in = chi_in + HI_W'(ph_ff[i+15]);
            clo_in = clo_in + LO_W'(pl_ff[i+15]);
         end
      end
      for (int i = 6; i < 15; i++) begin
         bhi_in = bhi_in + HI_W'(ph_ff[i]);
         blo_in = blo_in + LO_W'(pl_ff[i]);
      end
      bl_in = LIN_W'(lp2_ff[0]) + LIN_W'(lp2_ff[1]) + LIN_W'(lp2_ff[2]);
      cl_in = LIN_W'(lp2_ff[3]) + LIN_W'(lp2_ff[4]) + LIN_W'(lp2_ff[5]);
   end

   // Stage 4: exact a, b, c at 3F fraction bits.
   always_comb begin
      sa_in = (SUM_W'(ahi_ff) <<< 32) + SUM_W'(alo_ff);
      sb_in = ((SUM_W'(bhi_ff) <<< 32) + SUM_W'(blo_ff)
               + (SUM_W'(bl_ff) <<< FRAC_BITS)) <<< 1;
      sc_in = (SUM_W'(chi_ff) <<< 32) + SUM_W'(clo_ff)
              + (SUM_W'(cl_ff) <<< (FRAC_BITS + 1))
              + (SUM_W'(coef.k) <<< (2 * FRAC_BITS));
   end

   // Stage 5: floor to Q.F and check range and a nonzero leading term.
   always_comb begin
      fa = sa_ff >>> (2 * FRAC_BITS);
      fb = sb_ff >>> (2 * FRAC_BITS);
      fc = sc_ff >>> (2 * FRAC_BITS);
      ok5_in = ((fa[SUM_W-1:Q_W-1] == '0) || (fa[SUM_W-1:Q_W-1] == '1))
            && ((fb[SUM_W-1:Q_W-1] == '0) || (fb[SUM_W-1:Q_W-1] == '1))
            && ((fc[SUM_W-1:Q_W-1] == '0) || (fc[SUM_W-1:Q_W-1] == '1))
            && (fa[Q_W-1:0] != '0);
   end

   // Stage 6: split b*b and a*c into half-width partial products.
   always_comb begin
      ah = $signed(qa_ff[Q_W-1:HALF]);
      bh = $signed(qb_ff[Q_W-1:HALF]);
      ch = $signed(qc_ff[Q_W-1:HALF]);
      al = $signed({1'b0, qa_ff[HALF-1:0]});
      bl = $signed({1'b0, qb_ff[HALF-1:0]});
      cl = $signed({1'b0, qc_ff[HALF-1:0]});
      bhh_in = bh * bh;
      bhl_in = bh * bl;
      bll_in = bl * bl;
      ahh_in = ah * ch;
      ahl_in = ah * cl;
      alh_in = al * ch;
      all_in = al * cl;
   end

   // Stage 7: recombine the partial products.
   always_comb begin
      bb_in = (DISC_W'(bhh_ff) <<< (2 * HALF)) + (DISC_W'(bhl_ff) <<< (HALF + 1))
              + DISC_W'(bll_ff);
      ac_in = (DISC_W'(ahh_ff) <<< (2 * HALF))
              + ((DISC_W'(ahl_ff) + DISC_W'(alh_ff)) <<< HALF) + DISC_W'(all_ff);
   end

   // Stage 8 forms the discriminant; stage 9 classifies it.
   always_comb begin
      disc_in = bb_ff - (ac_ff <<< 2);
      two = ok8_ff && (disc_ff > DISC_W'(EPS_D_HI));
      tan = ok8_ff && (disc_ff < DISC_W'(EPS_D_LO)) && (disc_ff > DISC_W'(-EPS_D_LO));
      out_in.a    = a8_ff;
      out_in.b    = b8_ff;
      out_in.rad  = two ? disc_ff[RAD_W-1:0] : '0;
      out_in.mode = two ? MODE_TWO : (tan ? MODE_TANGENT : MODE_NONE);
   end

   // Pipeline registers; all stages move together.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[7:0], up_vld};
      end
      if (en) begin
         qp_ff  <= qp_in;
         lp_ff  <= lp_in;
         ph_ff  <= ph_in;
         pl_ff  <= pl_in;
         lp2_ff <= lp_ff;
         ahi_ff <= ahi_in; alo_ff <= alo_in;
         bhi_ff <= bhi_in; blo_ff <= blo_in;
         chi_ff <= chi_in; clo_ff <= clo_in;
         bl_ff  <= bl_in;  cl_ff  <= cl_in;
         sa_ff  <= sa_in;  sb_ff  <= sb_in;  sc_ff <= sc_in;
         qa_ff  <= fa[Q_W-1:0];
         qb_ff  <= fb[Q_W-1:0];
         qc_ff  <= fc[Q_W-1:0];
         ok5_ff <= ok5_in;
         bhh_ff <= bhh_in; bhl_ff <= bhl_in; bll_ff <= bll_in;
         ahh_ff <= ahh_in; ahl_ff <= ahl_in; alh_ff <= alh_in; all_ff <= all_in;
         a6_ff  <= qa_ff;  b6_ff  <= qb_ff;  ok6_ff <= ok5_ff;
         bb_ff  <= bb_in;  ac_ff  <= ac_in;
         a7_ff  <= a6_ff;  b7_ff  <= b6_ff;  ok7_ff <= ok6_ff;
         disc_ff <= disc_in;
         a8_ff  <= a7_ff;  b8_ff  <= b7_ff;  ok8_ff <= ok7_ff;
         out_ff <= out_in;
      end
   end

   assign dn_vld  = vld_ff[8];
   assign dn_data = out_ff;

endmodule

/* design/ray_quadric_intersect.sv */
// Throughput: one ray per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, and holds otherwise.
// A ray passes the quadratic build, the 61 square-root cells, one root bit each, and the 32 divider cells.
// Reset clears all valid flags and the coefficient registers to zero.
module ray_quadric_intersect (
   input  logic         clock,
   input  logic         reset,
   // Configuration write port.
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_wdata,
   // Request: dir_x, dir_y, dir_z, origin_x, origin_y, origin_z (32 bits each).
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,
   // Response: hit, t_hit[31:0], root_kind[1:0], zero pad.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata
);
   import rqi_pkg::*;

   localparam logic [2:0] CSR_COEF_A_B = 3'd0;
   localparam logic [2:0] CSR_COEF_C_D = 3'd1;
   localparam logic [2:0] CSR_COEF_E_F = 3'd2;
   localparam logic [2:0] CSR_COEF_G_H = 3'd3;
   localparam logic [2:0] CSR_COEF_J_K = 3'd4;

   logic [63:0] coef_ab_ff, coef_cd_ff, coef_ef_ff, coef_gh_ff, coef_jk_ff;
   coef_type    coef;
   ray_type     ray;
   logic        en;

   logic     quad_vld;
   quad_type quad;

   logic   sq_vld  [SQRT_CELLS+1];
   sq_type sq_data [SQRT_CELLS+1];

   logic signed [NUM_W-1:0] nb;
   logic signed [NUM_W-1:0] root_s;
   logic signed [NUM_W-1:0] num1_in, num2_in, num1_ff, num2_ff;
   logic signed [Q_W-1:0]   a1_ff;
   mode_type                mode1_ff;
   logic                    su1_vld_ff;

   logic [MAG_W-1:0] mag1, mag2;
   logic [Q_W-1:0]   amag;
   logic [N_W-1:0]   n1, n2;
   dv_type           dv_in, dv_ff;
   logic             su2_vld_ff;

   logic   dv_vld  [DIV_CELLS+1];
   dv_type dv_data [DIV_CELLS+1];

   dv_type           d;
   logic             gt1, gt2, big1, big2;
   logic             lo_gt, hi_gt, lo_big, hi_big;
   logic [QUO_W-1:0] lo_q, hi_q;
   kind_type         kind;
   logic [QUO_W-1:0] t_sel;
   logic             big;
   logic             hit_in, hit_ff;
   logic [31:0]      t_in, t_ff;
   kind_type         kind_in, kind_ff;
   logic             rsp_vld_ff;

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ab_ff <= '0;
         coef_cd_ff <= '0;
         coef_ef_ff <= '0;
         coef_gh_ff <= '0;
         coef_jk_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_A_B: coef_ab_ff <= csr_wdata;
            CSR_COEF_C_D: coef_cd_ff <= csr_wdata;
            CSR_COEF_E_F: coef_ef_ff <= csr_wdata;
            CSR_COEF_G_H: coef_gh_ff <= csr_wdata;
            CSR_COEF_J_K: coef_jk_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.a = $signed(coef_ab_ff[63:32]); coef.b = $signed(coef_ab_ff[31:0]);
      coef.c = $signed(coef_cd_ff[63:32]); coef.d = $signed(coef_cd_ff[31:0]);
      coef.e = $signed(coef_ef_ff[63:32]); coef.f = $signed(coef_ef_ff[31:0]);
      coef.g = $signed(coef_gh_ff[63:32]); coef.h = $signed(coef_gh_ff[31:0]);
      coef.j = $signed(coef_jk_ff[63:32]); coef.k = $signed(coef_jk_ff[31:0]);
      ray    = req_tdata;
   end

   // The pipeline moves unless a finished word is waiting at the output.
   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   rqi_quad u_quad (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .up_vld  (req_tvalid),
      .ray     (ray),
      .coef    (coef),
      .dn_vld  (quad_vld),
      .dn_data (quad)
   );

   // Square-root chain.
   assign sq_vld[0]  = quad_vld;
   assign sq_data[0] = '{rad: quad.rad, root: '0, rem: '0, a: quad.a, b: quad.b,
                         mode: quad.mode};

   for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
      rqi_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_vld  (sq_vld[i]),
         .up_data (sq_data[i]),
         .dn_vld  (sq_vld[i+1]),
         .dn_data (sq_data[i+1])
      );
   end

   // Numerators: -b + s and -b - s, or -b alone for the tangent root.
   always_comb begin
      nb      = NUM_W'(0) - NUM_W'($signed(sq_data[SQRT_CELLS].b));
      root_s  = $signed(NUM_W'(sq_data[SQRT_CELLS].root));
      num1_in = (sq_data[SQRT_CELLS].mode == MODE_TWO) ? nb + root_s : nb;
      num2_in = nb - root_s;
   end

   // Divider setup: magnitudes, signs, divisor 2|a| and quotient overflow.
   always_comb begin
      mag1 = num1_ff[NUM_W-1] ? MAG_W'(-num1_ff) : MAG_W'(num1_ff);
      mag2 = num2_ff[NUM_W-1] ? MAG_W'(-num2_ff) : MAG_W'(num2_ff);
      amag = a1_ff[Q_W-1] ? Q_W'(-a1_ff) : Q_W'(a1_ff);
      n1   = N_W'(mag1) << FRAC_BITS;
      n2   = N_W'(mag2) << FRAC_BITS;
      dv_in.dm    = {amag, 1'b0};
      dv_in.ovf1  = (n1 >> QUO_W) >= N_W'(dv_in.dm);
      dv_in.ovf2  = (n2 >> QUO_W) >= N_W'(dv_in.dm);
      dv_in.rem1  = DEN_W'(n1 >> QUO_W);
      dv_in.rem2  = DEN_W'(n2 >> QUO_W);
      dv_in.n1    = n1[QUO_W-1:0];
      dv_in.n2    = n2[QUO_W-1:0];
      dv_in.q1    = '0;
      dv_in.q2    = '0;
      dv_in.neg1  = num1_ff[NUM_W-1] ^ a1_ff[Q_W-1];
      dv_in.neg2  = num2_ff[NUM_W-1] ^ a1_ff[Q_W-1];
      dv_in.a_pos = !a1_ff[Q_W-1];
      dv_in.mode  = mode1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         su1_vld_ff <= 1'b0;
         su2_vld_ff <= 1'b0;
      end else if (en) begin
         su1_vld_ff <= sq_vld[SQRT_CELLS];
         su2_vld_ff <= su1_vld_ff;
      end
      if (en) begin
         num1_ff  <= num1_in;
         num2_ff  <= num2_in;
         a1_ff    <= sq_data[SQRT_CELLS].a;
         mode1_ff <= sq_data[SQRT_CELLS].mode;
         dv_ff    <= dv_in;
      end
   end

   // Divider chain.
   assign dv_vld[0]  = su2_vld_ff;
   assign dv_data[0] = dv_ff;

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      rqi_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .up_vld  (dv_vld[i]),
         .up_data (dv_data[i]),
         .dn_vld  (dv_vld[i+1]),
         .dn_data (dv_data[i+1])
      );
   end

   // Root choice: nearest root above the threshold; an oversized root is a miss.
   always_comb begin
      d      = dv_data[DIV_CELLS];
      gt1    = !d.neg1 && (d.ovf1 || (d.q1 > QUO_W'(EPS_T)));
      gt2    = !d.neg2 && (d.ovf2 || (d.q2 > QUO_W'(EPS_T)));
      big1   = d.ovf1 || d.q1[QUO_W-1];
      big2   = d.ovf2 || d.q2[QUO_W-1];
      lo_gt  = d.a_pos ? gt2  : gt1;
      hi_gt  = d.a_pos ? gt1  : gt2;
      lo_big = d.a_pos ? big2 : big1;
      hi_big = d.a_pos ? big1 : big2;
      lo_q   = d.a_pos ? d.q2 : d.q1;
      hi_q   = d.a_pos ? d.q1 : d.q2;
      kind   = KIND_NONE;
      t_sel  = '0;
      big    = 1'b0;
      unique case (d.mode)
         MODE_TWO: begin
            if (lo_gt) begin
               kind = KIND_NEAR; t_sel = lo_q; big = lo_big;
            end else if (hi_gt) begin
               kind = KIND_FAR; t_sel = hi_q; big = hi_big;
            end
         end
         MODE_TANGENT: begin
            if (gt1) begin
               kind = KIND_TANGENT; t_sel = d.q1; big = big1;
            end
         end
         default: ;
      endcase
      if (big) begin
         kind = KIND_NONE;
      end
      hit_in  = kind != KIND_NONE;
      kind_in = kind;
      t_in    = hit_in ? t_sel : '0;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= dv_vld[DIV_CELLS];
      end
      if (en) begin
         hit_ff  <= hit_in;
         t_ff    <= t_in;
         kind_ff <= kind_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b0, kind_ff, t_ff, hit_ff};

endmodule

/* dv/tb_ray_quadric_intersect.sv */
// Self-checking testbench of the ray / general quadric intersection pipeline.
module tb_ray_quadric_intersect;
   import rqi_pkg::*;

   typedef logic signed [127:0] wide_type;

   // One expected response word.
   typedef struct {
      logic        hit;
      logic [31:0] t_hit;
      kind_type    kind;
   } hit_type;

   // One row of the directed table; expectations are typed in where chk is set.
   typedef struct {
      ray_type  ray;
      bit       sphere;
      bit       chk;
      hit_type  want;
   } row_type;

   localparam int SETTLE = 130;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [2:0]   csr_index;
   logic [63:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [191:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [39:0]  rsp_tdata;

   coef_type     surface;
   hit_type      hits_due[$];
   int           errors;
   bit           quiet;
   bit           hold_now;
   bit           hold_done;

   ray_quadric_intersect u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [31:0] q16(int v);
      return 32'(v <<< FRAC_BITS);
   endfunction

   // (num * 2^F) / den truncated toward zero, magnitude clamped to 2^40.
   function automatic wide_type ratio_q(wide_type num, wide_type den);
      wide_type n, d, q;
      n = (num < 0 ? -num : num) <<< FRAC_BITS;
      d = den < 0 ? -den : den;
      q = n / d;
      if (q > (wide_type'(1) <<< 40)) q = wide_type'(1) <<< 40;
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   // Nearest valid intersection of one ray with the current surface.
   function automatic hit_type trace_ray(ray_type r);
      wide_type dx, dy, dz, ex, ey, ez, one, lim;
      wide_type qa, qb, qc, qd, qe, qf, qg, qh, qj, qk;
      wide_type wa, wb, wc, a, b, c, disc, root, cand, tp, tm, lo, hi, t;
      hit_type  res;
      dx = $signed(r.dir_x);    dy = $signed(r.dir_y);    dz = $signed(r.dir_z);
      ex = $signed(r.origin_x); ey = $signed(r.origin_y); ez = $signed(r.origin_z);
      qa = surface.a; qb = surface.b; qc = surface.c; qd = surface.d; qe = surface.e;
      qf = surface.f; qg = surface.g; qh = surface.h; qj = surface.j; qk = surface.k;
      one = wide_type'(1) <<< FRAC_BITS;
      lim = wide_type'(1) <<< 59;
      res = '{1'b0, 32'd0, KIND_NONE};
      t = 0;

      // Quadratic terms exact at 3F fraction bits.
      wa = qa*dx*dx + qb*dy*dy + qc*dz*dz + 2*(qd*dx*dy + qe*dy*dz + qf*dx*dz);
      wb = 2*(qa*ex*dx + qb*ey*dy + qc*ez*dz + qd*(ex*dy + ey*dx) + qe*(ey*dz + ez*dy)
            + qf*(ez*dx + ex*dz) + (qg*dx + qh*dy + qj*dz)*one);
      wc = qa*ex*ex + qb*ey*ey + qc*ez*ez
         + 2*(qd*ex*ey + qe*ey*ez + qf*ez*ex + (qg*ex + qh*ey + qj*ez)*one) + qk*one*one;
      a = wa >>> (2*FRAC_BITS);
      b = wb >>> (2*FRAC_BITS);
      c = wc >>> (2*FRAC_BITS);
      if (a < -lim || a >= lim || b < -lim || b >= lim || c < -lim || c >= lim || a == 0)
         return res;

      disc = b*b - 4*a*c;
      if (disc > EPS_D_HI) begin
         root = 0;
         for (int i = 60; i >= 0; i--) begin
            cand = root | (wide_type'(1) <<< i);
            if (cand*cand <= disc) root = cand;
         end
         tp = ratio_q(-b + root, 2*a);
         tm = ratio_q(-b - root, 2*a);
         lo = a > 0 ? tm : tp;
         hi = a > 0 ? tp : tm;
         if (lo > EPS_T) begin
            t = lo; res.kind = KIND_NEAR;
         end else if (hi > EPS_T) begin
            t = hi; res.kind = KIND_FAR;
         end
      end else if (disc < EPS_D_LO && disc > -EPS_D_LO) begin
         t = ratio_q(-b, 2*a);
         if (t > EPS_T) res.kind = KIND_TANGENT;
      end
      // A root beyond the Q16.16 range is no hit.
      if (res.kind != KIND_NONE && t > 32'sh7fffffff) res.kind = KIND_NONE;
      if (res.kind != KIND_NONE) begin
         res.hit = 1'b1;
         res.t_hit = t[31:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
   endtask

   // Response checking against the oldest outstanding expectation.
   always @(posedge clock) begin
      hit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hits_due.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
         end else begin
            want = hits_due.pop_front();
            if (rsp_tdata[0] !== want.hit)
               report_mismatch("hit", 32'(rsp_tdata[0]), 32'(want.hit));
            if (rsp_tdata[32:1] !== want.t_hit)
               report_mismatch("t_hit", rsp_tdata[32:1], want.t_hit);
            if (rsp_tdata[34:33] !== want.kind)
               report_mismatch("root_kind", 32'(rsp_tdata[34:33]), 32'(want.kind));
         end
      end
   end

   // Receiver back-pressure: random bursts, one long hold-off, none at the end.
   initial begin
      int n;
      rsp_tready = 1'b0;
      hold_done = 1'b0;
      forever begin
         if (quiet) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (hold_now && !hold_done) begin
            for (int i = 0; i < 400; i++) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
            hold_done = 1'b1;
         end else begin
            n = $urandom_range(1, 18);
            for (int i = 0; i < n; i++) begin
               @(negedge clock);
               rsp_tready <= 1'b1;
            end
            if ($urandom_range(0, 2) == 0) begin
               n = $urandom_range(1, 18);
               for (int i = 0; i < n; i++) begin
                  @(negedge clock);
                  rsp_tready <= 1'b0;
               end
            end
         end
      end
   end

   // Offer one ray, sometimes after a random gap, and record its expectation.
   task automatic send_ray(ray_type r, bit chk, hit_type want);
      hit_type calc;
      int      gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         for (int i = 0; i < gap; i++) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      do @(posedge clock); while (!req_tready);
      calc = trace_ray(r);
      if (chk && (calc.hit !== want.hit || calc.t_hit !== want.t_hit || calc.kind !== want.kind))
         report_mismatch("predictor vs table", calc.t_hit, want.t_hit);
      hits_due.push_back(calc);
   endtask

   // Wait until the pipeline has drained.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (hits_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write all five coefficient registers while the pipeline is empty.
   task automatic load_surface(coef_type cf);
      logic [63:0] regs [5];
      drain();
      surface = cf;
      regs[0] = {cf.a, cf.b};
      regs[1] = {cf.c, cf.d};
      regs[2] = {cf.e, cf.f};
      regs[3] = {cf.g, cf.h};
      regs[4] = {cf.j, cf.k};
      for (int i = 0; i < 5; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= regs[i];
      end
      // An index past the last register is ignored.
      @(negedge clock);
      csr_index <= 3'($urandom_range(5, 7));
      csr_wdata <= {$urandom, $urandom};
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic coef_type sphere(int r2);
      coef_type cf;
      cf = '0;
      cf.a = q16(1); cf.b = q16(1); cf.c = q16(1);
      cf.k = q16(-r2);
      return cf;
   endfunction

   function automatic coef_type small_surface();
      coef_type cf;
      logic [319:0] bits;
      for (int i = 0; i < 10; i++)
         bits[i*32 +: 32] = 32'($signed($urandom_range(0, 8*65536)) - 4*65536);
      cf = bits;
      return cf;
   endfunction

   function automatic coef_type noise_surface();
      coef_type cf;
      logic [319:0] bits;
      for (int i = 0; i < 10; i++) bits[i*32 +: 32] = $urandom;
      cf = bits;
      return cf;
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      if ($urandom_range(0, 4) == 0) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end else begin
         r.dir_x    = 32'($signed($urandom_range(0, 4*65536)) - 2*65536);
         r.dir_y    = 32'($signed($urandom_range(0, 4*65536)) - 2*65536);
         r.dir_z    = 32'($signed($urandom_range(0, 4*65536)) - 2*65536);
         r.origin_x = 32'($signed($urandom_range(0, 16*65536)) - 8*65536);
         r.origin_y = 32'($signed($urandom_range(0, 16*65536)) - 8*65536);
         r.origin_z = 32'($signed($urandom_range(0, 16*65536)) - 8*65536);
      end
      return r;
   endfunction

   function automatic ray_type mk_ray(int dx, int dy, int dz, int ox, int oy, int oz);
      ray_type r;
      r.dir_x = q16(dx); r.dir_y = q16(dy); r.dir_z = q16(dz);
      r.origin_x = q16(ox); r.origin_y = q16(oy); r.origin_z = q16(oz);
      return r;
   endfunction

   // Main sequence: directed table, then random phases over several surfaces.
   initial begin
      row_type  rows [$];
      hit_type  none;
      hit_type  unused;
      ray_type  r;
      coef_type extreme;
      bit       sphere_set;

      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      quiet      = 1'b0;
      hold_now   = 1'b0;
      errors     = 0;
      surface    = '0;
      none       = '{1'b0, 32'd0, KIND_NONE};
      unused     = none;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Coefficients are zero after reset, so every ray misses.
      rows.push_back('{'0, 0, 1, none});
      rows.push_back('{{6{32'h7fffffff}}, 0, 1, none});
      rows.push_back('{{6{32'h80000000}}, 0, 1, none});
      rows.push_back('{{3{32'h80000000, 32'h7fffffff}}, 0, 1, none});
      rows.push_back('{{6{32'hffffffff}}, 0, 1, none});
      // Sphere of radius 2 at the origin.
      rows.push_back('{mk_ray(0, 0, 1, 0, 0, -5), 1, 1, '{1'b1, q16(3), KIND_NEAR}});
      rows.push_back('{mk_ray(0, 0, 1, 0, 0, 0), 1, 1, '{1'b1, q16(2), KIND_FAR}});
      rows.push_back('{mk_ray(0, 0, 1, 2, 0, -5), 1, 1, '{1'b1, q16(5), KIND_TANGENT}});
      rows.push_back('{mk_ray(0, 0, 1, 3, 0, -5), 1, 1, none});
      rows.push_back('{mk_ray(0, 0, 1, 0, 0, 5), 1, 1, none});
      rows.push_back('{mk_ray(0, 0, 0, 0, 0, -5), 1, 1, none});
      rows.push_back('{mk_ray(0, 0, -1, 0, 0, 5), 1, 1, '{1'b1, q16(3), KIND_NEAR}});
      r = mk_ray(0, 0, 0, 0, 0, -5);
      r.dir_z = 32'd1;
      rows.push_back('{r, 1, 1, none});
      rows.push_back('{mk_ray(1, 1, 1, -4, -4, -4), 1, 0, unused});
      rows.push_back('{{6{32'h7fffffff}}, 1, 0, unused});
      rows.push_back('{{6{32'h80000000}}, 1, 0, unused});
      rows.push_back('{mk_ray(0, 1, 0, 0, -2, 0), 1, 0, unused});

      sphere_set = 1'b0;
      foreach (rows[i]) begin
         if (rows[i].sphere && !sphere_set) begin
            load_surface(sphere(4));
            sphere_set = 1'b1;
         end
         send_ray(rows[i].ray, rows[i].chk, rows[i].want);
      end

      // Random phases; the receiver holds off once while rays keep coming.
      load_surface(sphere($urandom_range(1, 30)));
      for (int i = 0; i < 100; i++) begin
         if (i == 20) hold_now = 1'b1;
         send_ray(random_ray(), 0, unused);
      end
      load_surface(small_surface());
      for (int i = 0; i < 100; i++) send_ray(random_ray(), 0, unused);
      load_surface(noise_surface());
      for (int i = 0; i < 60; i++) send_ray(random_ray(), 0, unused);
      extreme = {10{32'h7fffffff}};
      load_surface(extreme);
      for (int i = 0; i < 40; i++) send_ray(random_ray(), 0, unused);
      extreme = {10{32'h80000000}};
      load_surface(extreme);
      for (int i = 0; i < 40; i++) send_ray(random_ray(), 0, unused);
      load_surface(small_surface());
      for (int i = 0; i < 60; i++) send_ray(random_ray(), 0, unused);

      // Last stretch at full rate on both sides.
      load_surface(sphere($urandom_range(1, 30)));
      quiet = 1'b1;
      for (int i = 0; i < 100; i++) send_ray(random_ray(), 0, unused);
      drain();

      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
